/* rtl/dltq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and codes of the delta list timer queue: request and
// response payloads, operation, kind and status codes, default sizes.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int MaxTimersDef = 16;
  localparam int TickWidthDef = 32;

  localparam int FuncWidth   = 2;
  localparam int IdWidth     = 4;
  localparam int TicksWidth  = 32;
  localparam int KindWidth   = 2;
  localparam int StatusWidth = 3;

  localparam logic [FuncWidth-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FuncWidth-1:0] FUNC_START  = 2'd1;
  localparam logic [FuncWidth-1:0] FUNC_CANCEL = 2'd2;

  localparam logic [KindWidth-1:0] KIND_ACK     = 2'd0;
  localparam logic [KindWidth-1:0] KIND_EXPIRED = 2'd1;
  localparam logic [KindWidth-1:0] KIND_ERROR   = 2'd2;

  localparam logic [StatusWidth-1:0] STATUS_OK       = 3'd0;
  localparam logic [StatusWidth-1:0] STATUS_FULL     = 3'd1;
  localparam logic [StatusWidth-1:0] STATUS_ACTIVE   = 3'd2;
  localparam logic [StatusWidth-1:0] STATUS_INACTIVE = 3'd3;
  localparam logic [StatusWidth-1:0] STATUS_SMALL    = 3'd4;

  typedef struct packed {
    logic [FuncWidth-1:0]  func;
    logic [IdWidth-1:0]    timer_id;
    logic [TicksWidth-1:0] ticks;
  } req_t;

  typedef struct packed {
    logic [KindWidth-1:0]   kind;
    logic [IdWidth-1:0]     timer_id_out;
    logic [StatusWidth-1:0] status;
    logic [TicksWidth-1:0]  now;
    logic                   last;
  } rsp_t;

endpackage
`default_nettype wire

/* rtl/dltq_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_req_if
// Request channel: valid/ready handshake carrying one timer request.
// ----------------------------------------------------------------------------
interface dltq_req_if import dltq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/dltq_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_rsp_if
// Response channel: valid/ready handshake carrying one timer response.
// ----------------------------------------------------------------------------
interface dltq_rsp_if import dltq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/delta_list_timer_queue_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// delta_list_timer_queue_top
// Timer queue kept as a delta list in a circular slot memory, walked by a
// small sequencer around one shared adder/subtractor.
// ----------------------------------------------------------------------------
// One request is handled at a time; the request side is ready only while the
// sequencer is idle. Every slot visit has an address state for the single-port
// slot memory and an evaluate state that uses its registered read data with the
// shared adder. A start walks the list and either appends the timer or inserts
// it and shifts the slots behind it; a cancel walks up to the timer and moves the
// slots behind it up; a tick decrements the head delta and reports each expired
// timer in its own response. Each response is held until taken before the next
// step goes on. The slot memory needs no clearing after reset: only slots inside
// the armed range are read.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_top import dltq_pkg::*; #(
  parameter int MAX_TIMERS = MaxTimersDef,
  parameter int TICK_WIDTH = TickWidthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dltq_req_if.sink    req_i,
  dltq_rsp_if.source  rsp_o
);

  localparam int PW = $clog2(MAX_TIMERS);
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int TW = TICK_WIDTH;
  localparam int NumIdsW = 1 << IdWidth;

  typedef struct packed {
    logic [IdWidth-1:0] id;
    logic [TW-1:0]      delta;
  } slot_t;

  typedef struct packed {
    logic [KindWidth-1:0]   kind;
    logic [IdWidth-1:0]     id;
    logic [StatusWidth-1:0] status;
    logic                   last;
  } res_t;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_ST_RD  = 16'h0002,
    S_ST_EV  = 16'h0004,
    S_ST_ADJ = 16'h0008,
    S_SH_RD  = 16'h0010,
    S_SH_EV  = 16'h0020,
    S_CA_RD  = 16'h0040,
    S_CA_EV  = 16'h0080,
    S_CD_RD  = 16'h0100,
    S_CD_EV  = 16'h0200,
    S_TK_RD  = 16'h0400,
    S_TK_EV  = 16'h0800,
    S_TK_EX  = 16'h1000,
    S_TX_RD  = 16'h2000,
    S_TX_EV  = 16'h4000,
    S_OUT    = 16'h8000
  } state_e;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(MAX_TIMERS - 1)) ? '0 : p + PW'(1);
  endfunction

  state_e              state_q, state_d;
  logic [PW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [NumIdsW-1:0]  active_q, active_d;
  logic [TW-1:0]       now_q, now_d;
  logic                first_q, first_d;
  logic                more_q, more_d;
  logic [IdWidth-1:0]  id_q, id_d;
  logic [IdWidth-1:0]  exp_q, exp_d;
  logic [TW-1:0]       t_q, t_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [PW-1:0]       ptr_q, ptr_d;
  slot_t               carry_q, carry_d;
  res_t                res_q, res_d;

  slot_t               mem_q [MAX_TIMERS];
  slot_t               rd_q;
  logic [PW-1:0]       rd_addr;
  logic                wr_en;
  slot_t               wr_data;

  logic [TW-1:0]       alu_a, alu_b, alu_res;
  logic                alu_sub, alu_borrow;
  logic [TW:0]         alu_full;

  logic [PW-1:0]       ptr_inc, head_inc;
  logic                idx_at_count, idx1_at_count, idx2_at_count;

  assign ptr_inc  = wrap_inc(ptr_q);
  assign head_inc = wrap_inc(head_q);

  assign idx_at_count  = (idx_q == count_q);
  assign idx1_at_count = (({1'b0, idx_q} + (CW + 1)'(1)) == {1'b0, count_q});
  assign idx2_at_count = (({1'b0, idx_q} + (CW + 1)'(2)) == {1'b0, count_q});

  always_comb begin
    alu_a   = t_q;
    alu_b   = rd_q.delta;
    alu_sub = 1'b1;
    case (state_q)
      S_IDLE: begin
        alu_a   = now_q;
        alu_b   = TW'(1);
        alu_sub = 1'b0;
      end
      S_ST_ADJ: begin
        alu_a = carry_q.delta;
        alu_b = t_q;
      end
      S_CD_EV: begin
        alu_a   = rd_q.delta;
        alu_b   = t_q;
        alu_sub = 1'b0;
      end
      S_TK_EV: begin
        alu_a = rd_q.delta;
        alu_b = TW'(1);
      end
      default: ;
    endcase
  end

  assign alu_full   = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                              : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_res    = alu_full[TW-1:0];
  assign alu_borrow = alu_full[TW];

  assign rd_addr = (state_q == S_CD_RD) ? ptr_inc : ptr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[ptr_q] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    active_d = active_q;
    now_d    = now_q;
    first_d  = first_q;
    more_d   = more_q;
    id_d     = id_q;
    exp_d    = exp_q;
    t_d      = t_q;
    idx_d    = idx_q;
    ptr_d    = ptr_q;
    carry_d  = carry_q;
    res_d    = res_q;
    wr_en    = 1'b0;
    wr_data  = carry_q;

    case (state_q)
      S_IDLE: begin
        more_d = 1'b0;
        if (req_i.valid) begin
          id_d  = req_i.data.timer_id;
          t_d   = req_i.data.ticks[TW-1:0];
          idx_d = '0;
          ptr_d = head_q;
          case (req_i.data.func)
            FUNC_TICK: begin
              now_d = alu_res;
              if (count_q == '0) begin
                res_d   = '{KIND_ACK, '0, STATUS_OK, 1'b1};
                state_d = S_OUT;
              end else begin
                state_d = S_TK_RD;
              end
            end
            FUNC_START: begin
              state_d = S_OUT;
              if (active_q[req_i.data.timer_id]) begin
                res_d = '{KIND_ERROR, req_i.data.timer_id, STATUS_ACTIVE, 1'b1};
              end else if (count_q >= CW'(MAX_TIMERS)) begin
                res_d = '{KIND_ERROR, req_i.data.timer_id, STATUS_FULL, 1'b1};
              end else if (req_i.data.ticks[TW-1:1] == '0) begin
                res_d = '{KIND_ERROR, req_i.data.timer_id, STATUS_SMALL, 1'b1};
              end else begin
                state_d = S_ST_RD;
              end
            end
            FUNC_CANCEL: begin
              if (!active_q[req_i.data.timer_id]) begin
                res_d   = '{KIND_ERROR, req_i.data.timer_id, STATUS_INACTIVE, 1'b1};
                state_d = S_OUT;
              end else begin
                state_d = S_CA_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_ST_RD: state_d = S_ST_EV;

      S_ST_EV: begin
        if (idx_at_count) begin
          wr_en          = 1'b1;
          wr_data        = '{id_q, t_q};
          count_d        = count_q + CW'(1);
          active_d[id_q] = 1'b1;
          res_d          = '{KIND_ACK, id_q, STATUS_OK, 1'b1};
          state_d        = S_OUT;
        end else if (!alu_borrow) begin
          t_d     = alu_res;
          idx_d   = idx_q + CW'(1);
          ptr_d   = ptr_inc;
          state_d = S_ST_RD;
        end else begin
          wr_en   = 1'b1;
          wr_data = '{id_q, t_q};
          carry_d = rd_q;
          idx_d   = idx_q + CW'(1);
          ptr_d   = ptr_inc;
          state_d = S_ST_ADJ;
        end
      end

      S_ST_ADJ: begin
        carry_d.delta = alu_res;
        state_d       = S_SH_RD;
      end

      S_SH_RD: state_d = S_SH_EV;

      S_SH_EV: begin
        wr_en   = 1'b1;
        wr_data = carry_q;
        if (idx_at_count) begin
          count_d        = count_q + CW'(1);
          active_d[id_q] = 1'b1;
          res_d          = '{KIND_ACK, id_q, STATUS_OK, 1'b1};
          state_d        = S_OUT;
        end else begin
          carry_d = rd_q;
          idx_d   = idx_q + CW'(1);
          ptr_d   = ptr_inc;
          state_d = S_SH_RD;
        end
      end

      S_CA_RD: state_d = S_CA_EV;

      S_CA_EV: begin
        if (rd_q.id == id_q) begin
          if (idx1_at_count) begin
            count_d        = count_q - CW'(1);
            active_d[id_q] = 1'b0;
            res_d          = '{KIND_ACK, id_q, STATUS_OK, 1'b1};
            state_d        = S_OUT;
          end else begin
            t_d     = rd_q.delta;
            first_d = 1'b1;
            state_d = S_CD_RD;
          end
        end else begin
          idx_d   = idx_q + CW'(1);
          ptr_d   = ptr_inc;
          state_d = S_CA_RD;
        end
      end

      S_CD_RD: state_d = S_CD_EV;

      S_CD_EV: begin
        wr_en   = 1'b1;
        wr_data = rd_q;
        if (first_q) begin
          wr_data.delta = alu_res;
        end
        first_d = 1'b0;
        if (idx2_at_count) begin
          count_d        = count_q - CW'(1);
          active_d[id_q] = 1'b0;
          res_d          = '{KIND_ACK, id_q, STATUS_OK, 1'b1};
          state_d        = S_OUT;
        end else begin
          idx_d   = idx_q + CW'(1);
          ptr_d   = ptr_inc;
          state_d = S_CD_RD;
        end
      end

      S_TK_RD: state_d = S_TK_EV;

      S_TK_EV: begin
        if (rd_q.delta != '0) begin
          wr_en   = 1'b1;
          wr_data = '{rd_q.id, alu_res};
          if (alu_res == '0) begin
            state_d = S_TK_EX;
          end else begin
            res_d   = '{KIND_ACK, '0, STATUS_OK, 1'b1};
            state_d = S_OUT;
          end
        end else begin
          state_d = S_TK_EX;
        end
      end

      S_TK_EX: begin
        active_d[rd_q.id] = 1'b0;
        exp_d             = rd_q.id;
        head_d            = head_inc;
        ptr_d             = head_inc;
        count_d           = count_q - CW'(1);
        if (count_q == CW'(1)) begin
          res_d   = '{KIND_EXPIRED, rd_q.id, STATUS_OK, 1'b1};
          more_d  = 1'b0;
          state_d = S_OUT;
        end else begin
          state_d = S_TX_RD;
        end
      end

      S_TX_RD: state_d = S_TX_EV;

      S_TX_EV: begin
        res_d   = '{KIND_EXPIRED, exp_q, STATUS_OK, (rd_q.delta != '0)};
        more_d  = (rd_q.delta == '0);
        state_d = S_OUT;
      end

      S_OUT: begin
        if (rsp_o.ready) begin
          state_d = more_q ? S_TK_EX : S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      active_q <= '0;
      now_q    <= '0;
      first_q  <= 1'b0;
      more_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      active_q <= active_d;
      now_q    <= now_d;
      first_q  <= first_d;
      more_q   <= more_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    exp_q   <= exp_d;
    t_q     <= t_d;
    idx_q   <= idx_d;
    ptr_q   <= ptr_d;
    carry_q <= carry_d;
    res_q   <= res_d;
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = (state_q == S_OUT);
  assign rsp_o.data  = '{
    kind:         res_q.kind,
    timer_id_out: res_q.id,
    status:       res_q.status,
    now:          TicksWidth'(now_q),
    last:         res_q.last
  };

endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delta list timer queue. A directed sequence and
// weighted random traffic (start, cancel, tick and unused requests) are fed
// through the request channel. Each accepted request is applied to a local
// model of the delta list, and the responses it predicts are compared field
// by field with the responses taken from the block. Both channel sides idle
// and stall at random, in phases, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import dltq_pkg::*;

  localparam logic [FuncWidth-1:0] FUNC_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;

  dltq_req_if req_if ();
  dltq_rsp_if rsp_if ();

  delta_list_timer_queue_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [IdWidth-1:0]    slot_ids    [MaxTimersDef];
  logic [TicksWidth-1:0] slot_deltas [MaxTimersDef];
  int                    armed_count;
  logic [15:0]           active_map;
  logic [TicksWidth-1:0] tick_count;

  req_t req_backlog_q [$];
  rsp_t awaited_rsp_q [$];
  int   queued_cnt;
  int   accepted_cnt;
  int   fail_cnt;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_left;
  logic req_fired;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic rsp_t make_rsp(logic [KindWidth-1:0] kind, logic [IdWidth-1:0] id,
                                    logic [StatusWidth-1:0] status, logic last);
    rsp_t r;
    r.kind         = kind;
    r.timer_id_out = id;
    r.status       = status;
    r.now          = tick_count;
    r.last         = last;
    return r;
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < armed_count; i++) begin
      slot_ids[i]    = slot_ids[i+1];
      slot_deltas[i] = slot_deltas[i+1];
    end
    if (armed_count > 0) armed_count--;
  endfunction

  function automatic void timer_queue_apply(req_t r);
    int                    pos;
    int                    n;
    logic                  done;
    logic [IdWidth-1:0]    id;
    logic [TicksWidth-1:0] t;
    pos = 0;
    n   = 0;
    id  = r.timer_id;
    t   = r.ticks;
    case (r.func)
      FUNC_TICK: begin
        tick_count++;
        if (armed_count > 0 && slot_deltas[0] != '0) slot_deltas[0]--;
        while (armed_count > 0 && slot_deltas[0] == '0 && n < MaxTimersDef) begin
          id = slot_ids[0];
          active_map[id] = 1'b0;
          drop_slot(0);
          n++;
          done = !(armed_count > 0 && slot_deltas[0] == '0 && n < MaxTimersDef);
          awaited_rsp_q.push_back(make_rsp(KIND_EXPIRED, id, STATUS_OK, done));
        end
        if (n == 0) awaited_rsp_q.push_back(make_rsp(KIND_ACK, '0, STATUS_OK, 1'b1));
      end
      FUNC_START: begin
        if (active_map[id]) begin
          awaited_rsp_q.push_back(make_rsp(KIND_ERROR, id, STATUS_ACTIVE, 1'b1));
        end else if (armed_count >= MaxTimersDef) begin
          awaited_rsp_q.push_back(make_rsp(KIND_ERROR, id, STATUS_FULL, 1'b1));
        end else if (t < 2) begin
          awaited_rsp_q.push_back(make_rsp(KIND_ERROR, id, STATUS_SMALL, 1'b1));
        end else begin
          while (pos < armed_count && slot_deltas[pos] <= t) begin
            t = t - slot_deltas[pos];
            pos++;
          end
          for (int i = armed_count; i > pos; i--) begin
            slot_ids[i]    = slot_ids[i-1];
            slot_deltas[i] = slot_deltas[i-1];
          end
          slot_ids[pos]    = id;
          slot_deltas[pos] = t;
          armed_count++;
          if (pos + 1 < armed_count) slot_deltas[pos+1] = slot_deltas[pos+1] - t;
          active_map[id] = 1'b1;
          awaited_rsp_q.push_back(make_rsp(KIND_ACK, id, STATUS_OK, 1'b1));
        end
      end
      FUNC_CANCEL: begin
        if (!active_map[id]) begin
          awaited_rsp_q.push_back(make_rsp(KIND_ERROR, id, STATUS_INACTIVE, 1'b1));
        end else begin
          while (pos < armed_count && slot_ids[pos] != id) pos++;
          if (pos < armed_count) begin
            if (pos + 1 < armed_count) begin
              slot_deltas[pos+1] = slot_deltas[pos+1] + slot_deltas[pos];
            end
            drop_slot(pos);
          end
          active_map[id] = 1'b0;
          awaited_rsp_q.push_back(make_rsp(KIND_ACK, id, STATUS_OK, 1'b1));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // request driver
  always @(posedge clk_i) begin
    req_fired = rst_ni && req_if.valid && req_if.ready;
    if (req_fired) begin
      timer_queue_apply(req_if.data);
      accepted_cnt++;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fired) begin
      if (req_backlog_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid <= 1'b1;
        req_if.data  <= req_backlog_q.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response side: random stalls and long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : rsp_monitor
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (awaited_rsp_q.size() == 0) begin
        $error("unexpected response: kind %0d id %0d status %0d", rsp_if.data.kind,
               rsp_if.data.timer_id_out, rsp_if.data.status);
        fail_cnt++;
      end else begin
        want = awaited_rsp_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(rsp_if.data.kind));
        check_field("timer_id_out", 32'(want.timer_id_out),
                    32'(rsp_if.data.timer_id_out));
        check_field("status", 32'(want.status), 32'(rsp_if.data.status));
        check_field("now", want.now, rsp_if.data.now);
        check_field("last", 32'(want.last), 32'(rsp_if.data.last));
      end
    end
  end

  task automatic push_req(logic [FuncWidth-1:0] func, logic [IdWidth-1:0] id,
                          logic [TicksWidth-1:0] ticks);
    req_t r;
    r.func     = func;
    r.timer_id = id;
    r.ticks    = ticks;
    req_backlog_q.push_back(r);
    queued_cnt++;
  endtask

  task automatic drain();
    while (accepted_cnt != queued_cnt || awaited_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [TicksWidth-1:0] pick_delay();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(12, 2);
    if (sel < 80) return $urandom_range(1, 0);
    if (sel < 95) return $urandom_range(300, 13);
    return $urandom;
  endfunction

  // mostly well-formed bursts of starts followed by ticks, plus single noise
  task automatic fill_random(int budget);
    int n;
    int sel;
    int base;
    n = 0;
    while (n < budget) begin
      if ($urandom_range(3) == 0) begin
        base = $urandom_range(5, 2);
        for (int k = $urandom_range(5, 2); k > 0; k--) begin
          push_req(FUNC_START, IdWidth'($urandom_range(15)),
                   TicksWidth'(base + $urandom_range(2)));
          n++;
        end
        for (int k = base + 3; k > 0; k--) begin
          push_req(FUNC_TICK, IdWidth'($urandom_range(15)), $urandom);
          n++;
        end
      end else begin
        sel = $urandom_range(99);
        if (sel < 45) push_req(FUNC_TICK, IdWidth'($urandom_range(15)), $urandom);
        else if (sel < 78) push_req(FUNC_START, IdWidth'($urandom_range(15)), pick_delay());
        else if (sel < 97) push_req(FUNC_CANCEL, IdWidth'($urandom_range(15)), $urandom);
        else push_req(FUNC_UNUSED, IdWidth'($urandom_range(15)), $urandom);
        n++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    req_fired      = 1'b0;
    queued_cnt     = 0;
    accepted_cnt   = 0;
    fail_cnt       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    armed_count    = 0;
    active_map     = '0;
    tick_count     = '0;
    for (int i = 0; i < MaxTimersDef; i++) begin
      slot_ids[i]    = '0;
      slot_deltas[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    push_req(FUNC_TICK, 4'd0, 32'd0);
    push_req(FUNC_START, 4'd0, 32'd0);
    push_req(FUNC_START, 4'd1, 32'd1);
    push_req(FUNC_START, 4'd3, 32'hFFFF_FFFF);
    push_req(FUNC_START, 4'd5, 32'd3);
    push_req(FUNC_START, 4'd6, 32'd3);
    push_req(FUNC_START, 4'd8, 32'd3);
    push_req(FUNC_START, 4'd7, 32'd2);
    push_req(FUNC_START, 4'd15, 32'd5);
    push_req(FUNC_START, 4'd5, 32'd9);
    push_req(FUNC_CANCEL, 4'd9, 32'd0);
    push_req(FUNC_CANCEL, 4'd8, 32'hFFFF_FFFF);
    push_req(FUNC_UNUSED, 4'd15, 32'hFFFF_FFFF);
    push_req(FUNC_TICK, 4'd15, 32'hFFFF_FFFF);
    push_req(FUNC_TICK, 4'd0, 32'd0);
    push_req(FUNC_TICK, 4'd0, 32'd0);
    push_req(FUNC_TICK, 4'd0, 32'd0);
    push_req(FUNC_TICK, 4'd0, 32'd0);
    push_req(FUNC_CANCEL, 4'd3, 32'd0);
    push_req(FUNC_CANCEL, 4'd3, 32'd0);
    drain();

    // hold off the receiver so the block stalls its request side
    hold_left = 300;
    fill_random(85);
    drain();

    send_idle_pct  = 77;
    recv_stall_pct = 0;
    fill_random(85);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 77;
    fill_random(85);
    drain();

    send_idle_pct  = 25;
    recv_stall_pct = 25;
    fill_random(85);
    drain();

    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
rtl/dltq_pkg.sv
rtl/dltq_req_if.sv
rtl/dltq_rsp_if.sv
rtl/delta_list_timer_queue_top.sv
dv/tb.sv
